// ----- src/packet_crc16_appender_defines.svh -----
// ----------------------------------------------------------------------------
// packet_crc16_appender assertion macros
// shared concurrent assertion shorthands, clocked on clk_i, reset rst_ni
// ----------------------------------------------------------------------------
`ifndef PACKET_CRC16_APPENDER_DEFINES_SVH
`define PACKET_CRC16_APPENDER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pca_pkg.sv -----
// ----------------------------------------------------------------------------
// pca_pkg
// crc-16/modbus constants, the entry passed between stages, byte update
// ----------------------------------------------------------------------------
package pca_pkg;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // one accepted byte with its crc and end-of-packet flag
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] crc;
    logic        last;
  } entry_t;

  // reflected crc update, one byte lsb first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- src/pca_crc_stage.sv -----
// ----------------------------------------------------------------------------
// pca_crc_stage
// input register, running crc and byte count, feeds one entry downstream
// ----------------------------------------------------------------------------
`include "packet_crc16_appender_defines.svh"

module pca_crc_stage #(
  parameter int PACKET_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  output logic            ent_valid_o,
  input  logic            ent_ready_i,
  output pca_pkg::entry_t ent_o
);

  localparam int CntW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(PACKET_BYTES - 1);

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic [15:0]     crc_q, crc_d;
  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     crc_next;
  logic            is_last;
  logic            advance;

  assign advance    = in_valid_q && ent_ready_i;
  assign in_ready_o = !in_valid_q || ent_ready_i;

  assign crc_next = pca_pkg::crc16_update(crc_q, in_byte_q);
  assign is_last  = (count_q == LastCnt);

  always_comb begin
    crc_d   = crc_q;
    count_d = count_q;
    if (advance) begin
      if (is_last) begin
        crc_d   = pca_pkg::CRC_PRESET;
        count_d = '0;
      end else begin
        crc_d   = crc_next;
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      crc_q      <= pca_pkg::CRC_PRESET;
      count_q    <= '0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  assign ent_valid_o = in_valid_q;
  assign ent_o.data  = in_byte_q;
  assign ent_o.crc   = crc_next;
  assign ent_o.last  = is_last;

  `PCA_ASSERT_IMP(a_count_range, 1'b1, count_q <= LastCnt,
                  "byte count beyond packet length")
  `PCA_ASSERT_NXT(a_crc_preset_after_last, advance && is_last,
                  crc_q == pca_pkg::CRC_PRESET && count_q == '0,
                  "crc not preset after last byte")

endmodule

// ----- src/pca_out_stage.sv -----
// ----------------------------------------------------------------------------
// pca_out_stage
// result register, sends payload byte then crc low and high on packet end
// ----------------------------------------------------------------------------
`include "packet_crc16_appender_defines.svh"

module pca_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ent_valid_i,
  output logic            ent_ready_o,
  input  pca_pkg::entry_t ent_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_is_crc_o,
  output logic            out_end_o
);

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_e;

  phase_e          phase_q;
  logic            valid_q;
  pca_pkg::entry_t ent_q;
  logic            fire;
  logic            done;

  assign fire = valid_q && out_ready_i;
  assign done = fire && ((phase_q == PH_CRC_HI) || (phase_q == PH_DATA && !ent_q.last));
  assign ent_ready_o = !valid_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= PH_DATA;
    end else begin
      if (ent_valid_i && ent_ready_o) begin
        valid_q <= 1'b1;
        phase_q <= PH_DATA;
      end else if (done) begin
        valid_q <= 1'b0;
        phase_q <= PH_DATA;
      end else if (fire) begin
        case (phase_q)
          PH_DATA:   phase_q <= PH_CRC_LO;
          PH_CRC_LO: phase_q <= PH_CRC_HI;
          default:   phase_q <= PH_DATA;
        endcase
      end
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (ent_valid_i && ent_ready_o) begin
      ent_q <= ent_i;
    end
  end

  always_comb begin
    case (phase_q)
      PH_DATA:   out_byte_o = ent_q.data;
      PH_CRC_LO: out_byte_o = ent_q.crc[7:0];
      PH_CRC_HI: out_byte_o = ent_q.crc[15:8];
      default:   out_byte_o = ent_q.data;
    endcase
  end

  assign out_valid_o  = valid_q;
  assign out_is_crc_o = (phase_q != PH_DATA);
  assign out_end_o    = (phase_q == PH_CRC_HI);

  `PCA_ASSERT_IMP(a_end_on_crc, out_valid_o && out_end_o, out_is_crc_o,
                  "frame end on a payload byte")
  `PCA_ASSERT_IMP(a_crc_only_on_last, valid_q && phase_q != PH_DATA, ent_q.last,
                  "crc byte for a packet that has not ended")
  `PCA_ASSERT_NXT(a_hi_follows_lo, fire && phase_q == PH_CRC_LO,
                  out_valid_o && out_is_crc_o && out_end_o,
                  "crc high byte does not follow low byte")

endmodule

// ----- src/packet_crc16_appender.sv -----
// ----------------------------------------------------------------------------
// packet_crc16_appender
// pass-through byte stream with crc-16/modbus appended after each packet
// ----------------------------------------------------------------------------
// Payload bytes enter on the slave stream and leave unchanged on the master
// stream, one byte per cycle when the sink keeps tready high and no crc byte
// is going out. Every PACKET_BYTES bytes make one packet; after its last
// byte two more bytes go out: the crc low byte and then the crc high byte,
// both flagged in tuser, the high byte also carrying tlast. The crc (preset
// 0xFFFF, reflected polynomial 0xA001, lsb first) covers the payload bytes
// of the packet only and is preset again for the next packet. An input
// request passes through the input register and then the result register
// before its payload byte appears on the output. Throughput is one byte per
// cycle while the sink is ready; at packet end the single result register
// sends three bytes for the last request and takes no new entry meanwhile.
// The input register takes one more request while the output is stalled.
// ----------------------------------------------------------------------------
`include "packet_crc16_appender_defines.svh"

module packet_crc16_appender #(
  parameter int PACKET_BYTES = 8   // payload bytes per packet, 1 to 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // slave stream: payload bytes
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  // master stream: payload and crc bytes
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] is_crc
  output logic       m_axis_tlast_o    // frame_end, on the crc high byte
);

  // entry handshake between crc stage and output stage
  logic            ent_valid;
  logic            ent_ready;
  pca_pkg::entry_t ent;

  // input register plus crc update: the crc of the byte held in the input
  // register is computed in one pass and handed over with the byte
  pca_crc_stage #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_crc_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .ent_valid_o(ent_valid),
    .ent_ready_i(ent_ready),
    .ent_o      (ent)
  );

  // result register: one beat for a payload byte, three at packet end
  pca_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (ent_valid),
    .ent_ready_o (ent_ready),
    .ent_i       (ent),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_is_crc_o(m_axis_tuser_o),
    .out_end_o   (m_axis_tlast_o)
  );

  // a payload request is never taken while the input register is full and
  // the output stage holds its entry
  `PCA_ASSERT_IMP(a_no_overrun, s_axis_tready_o && !ent_ready, !ent_valid,
                  "input register overrun")

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for packet_crc16_appender: predicts payload and crc bytes
// ----------------------------------------------------------------------------
// A queue of payload bytes feeds the slave stream. Every accepted request goes
// through a bench-side crc-16/modbus model, which queues the bytes the block
// must send back: the payload byte, and at the end of each packet the crc low
// and high bytes. The monitor checks each master-stream byte against the
// oldest queued one. The run has three phases: a slow sink and a slow source,
// both with random gaps, and full rate with one long sink hold-off that backs
// the block up into its input.
// ----------------------------------------------------------------------------
module tb;

  localparam int PKT_LEN     = 8;     // payload bytes per packet
  localparam int RAND_BYTES  = 80;    // random payload bytes per phase
  localparam int HOLD_CYCLES = 300;   // long sink hold-off
  localparam int STALL_LIMIT = 3000;  // cycles without any transfer
  localparam int DRAIN_WAIT  = 20;    // settle time after the last byte

  // gap profile of the run
  typedef enum logic [1:0] {
    PH_SLOW_SINK,
    PH_SLOW_SOURCE,
    PH_FULL_RATE
  } gap_phase_e;

  // one byte as it should appear on the master stream
  typedef struct packed {
    logic [7:0] value;
    logic       is_crc;
    logic       frame_end;
  } tx_byte_t;

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;   // [7:0] data_byte
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;            // [7:0] out_byte
  logic       m_axis_tuser_o;            // [0] is_crc
  logic       m_axis_tlast_o;            // frame_end

  gap_phase_e gap_phase = PH_SLOW_SINK;
  logic       hold_arm  = 1'b0;

  logic [7:0] payload_q[$];    // bytes waiting to be offered
  tx_byte_t   tx_expect_q[$];  // bytes the block still owes us

  // bench copy of the block state
  logic [15:0] crc_acc  = pca_pkg::CRC_PRESET;
  int          pkt_fill = 0;

  int n_loaded   = 0;  // payload bytes put in the queue
  int n_taken    = 0;  // payload requests accepted by the block
  int n_expected = 0;  // output bytes predicted so far
  int n_seen     = 0;  // output bytes received so far
  int err_count  = 0;
  int quiet_cycles = 0;
  int hold_left  = 0;
  logic hold_used = 1'b0;

  packet_crc16_appender #(
    .PACKET_BYTES (PKT_LEN)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // percent of cycles in which each side idles, per phase
  function automatic int source_gap_pct(input gap_phase_e ph);
    case (ph)
      PH_SLOW_SINK:   return 13;
      PH_SLOW_SOURCE: return 72;
      default:        return 0;
    endcase
  endfunction

  function automatic int sink_gap_pct(input gap_phase_e ph);
    case (ph)
      PH_SLOW_SINK:   return 72;
      PH_SLOW_SOURCE: return 13;
      default:        return 0;
    endcase
  endfunction

  // crc-16/modbus over one byte, lsb first
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
                                                  input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ pca_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // queue the output bytes caused by one accepted payload byte
  task automatic predict_frame_bytes(input logic [7:0] b);
    logic [15:0] crc_new;
    crc_new = modbus_crc_step(crc_acc, b);
    tx_expect_q.push_back('{value: b, is_crc: 1'b0, frame_end: 1'b0});
    if (pkt_fill + 1 >= PKT_LEN) begin
      // last payload byte: append crc low then crc high, high one ends frame
      tx_expect_q.push_back('{value: crc_new[7:0], is_crc: 1'b1, frame_end: 1'b0});
      tx_expect_q.push_back('{value: crc_new[15:8], is_crc: 1'b1, frame_end: 1'b1});
      n_expected <= n_expected + 3;
      crc_acc  = pca_pkg::CRC_PRESET;
      pkt_fill = 0;
    end else begin
      n_expected <= n_expected + 1;
      crc_acc  = crc_new;
      pkt_fill = pkt_fill + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on output byte %0d: %s got 0x%0h, expected 0x%0h",
             n_seen, what, got, want);
    err_count++;
  endtask

  // source side: offer queued payload bytes, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'h00;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      // current request gone or none pending: decide on the next one
      if (payload_q.size() != 0 &&
          $urandom_range(99) >= source_gap_pct(gap_phase)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= payload_q.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // sink side: random ready, plus one long hold-off when armed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= 0;
      hold_used       <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left       <= HOLD_CYCLES;
      hold_used       <= 1'b1;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_gap_pct(gap_phase));
    end
  end

  // input monitor: every accepted payload request feeds the prediction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      predict_frame_bytes(s_axis_tdata_i);
      n_taken <= n_taken + 1;
    end
  end

  // output monitor: compare each accepted byte with the oldest prediction
  always @(posedge clk_i) begin
    tx_byte_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (tx_expect_q.size() == 0) begin
        report_mismatch("unexpected byte", int'(m_axis_tdata_o), 0);
      end else begin
        want = tx_expect_q.pop_front();
        if (m_axis_tdata_o !== want.value)
          report_mismatch("out_byte", int'(m_axis_tdata_o), int'(want.value));
        if (m_axis_tuser_o !== want.is_crc)
          report_mismatch("is_crc", int'(m_axis_tuser_o), int'(want.is_crc));
        if (m_axis_tlast_o !== want.frame_end)
          report_mismatch("frame_end", int'(m_axis_tlast_o), int'(want.frame_end));
      end
      n_seen <= n_seen + 1;
    end
  end

  // watchdog: too long without a transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic load_byte(input logic [7:0] b);
    payload_q.push_back(b);
    n_loaded++;
  endtask

  // random payload, with extra weight on the all-zero and all-one bytes
  task automatic load_random(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(15);
      if (pick == 0)
        load_byte(8'h00);
      else if (pick == 1)
        load_byte(8'hFF);
      else
        load_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic wait_all_taken();
    while (n_taken != n_loaded) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed packets: all zeros, all ones, walking one
    for (int i = 0; i < PKT_LEN; i++) load_byte(8'h00);
    for (int i = 0; i < PKT_LEN; i++) load_byte(8'hFF);
    for (int i = 0; i < PKT_LEN; i++) load_byte(8'h01 << (i % 8));
    load_random(RAND_BYTES);
    wait_all_taken();

    @(posedge clk_i);
    gap_phase <= PH_SLOW_SOURCE;
    load_random(RAND_BYTES);
    wait_all_taken();

    // full rate; the sink stalls for a long stretch so the input backs up
    @(posedge clk_i);
    gap_phase <= PH_FULL_RATE;
    load_random(RAND_BYTES);
    @(posedge clk_i);
    hold_arm <= 1'b1;
    wait_all_taken();

    while (n_seen != n_expected) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (tx_expect_q.size() != 0)
      report_mismatch("missing bytes", 0, tx_expect_q.size());

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
